/* design/bgys_pkg.sv */
`timescale 1ns / 1ps

package bgys_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned EXCESS_W = 26;

	localparam logic [1:0] REG_BAR_HEIGHT = 2'd0;
	localparam logic [1:0] REG_RECIPROCAL = 2'd1;
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;

	localparam logic [1:0] FMT_YUV444 = 2'd0;
	localparam logic [1:0] FMT_YUV422 = 2'd1;

	localparam logic [7:0] BLACK_LUMA = 8'd16;
	localparam logic [7:0] BLACK_CHROMA = 8'd128;

	typedef struct packed {
		logic [9:0]  row_index;
		logic        column_is_odd;
		logic [15:0] bar_level;
		logic [23:0] level_reciprocal;
		logic [7:0]  color_luma;
		logic [7:0]  color_cb;
		logic [7:0]  color_cr;
	} pixel_t;

	typedef struct packed {
		logic [7:0] luma_out;
		logic [7:0] cb_out;
		logic [7:0] cr_out;
		logic       chroma_valid;
	} shade_t;

	typedef struct packed {
		logic [10:0] bar_height;
		logic [15:0] reciprocal_bar_height;
		logic [1:0]  pixel_format;
	} cfg_t;

	typedef struct packed {
		logic [EXCESS_W-1:0] excess;
		logic [23:0]         rcp;
		logic [7:0]          luma;
		logic [7:0]          cb;
		logic [7:0]          cr;
		logic                chroma_valid;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* design/bgys_front.sv */
`timescale 1ns / 1ps

module bgys_front (
	input  logic            clk,
	input  logic            arst_n,
	input  bgys_pkg::cfg_t   cfg,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  bgys_pkg::pixel_t pixel,
	output logic            work_valid,
	input  logic            work_ready,
	output bgys_pkg::work_t  work
);

	logic                   valid_s1;
	bgys_pkg::pixel_t       pix_s1;
	logic signed [28:0]     thr_s1;
	logic                   valid_s2;
	bgys_pkg::work_t        work_s2;

	logic                   ready_s1;
	logic                   ready_s2;
	logic signed [11:0]     row_dist;
	logic signed [16:0]     rbh_s;
	logic signed [28:0]     thr;
	logic signed [28:0]     level_s;
	logic signed [28:0]     diff;
	logic                   cvalid;
	bgys_pkg::work_t        work_d;

	assign ready_s2 = !valid_s2 || work_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pixel_stall = !ready_s1;

	assign row_dist = $signed({1'b0, cfg.bar_height}) - $signed({2'b0, pixel.row_index});
	assign rbh_s = $signed({1'b0, cfg.reciprocal_bar_height});
	assign thr = row_dist * rbh_s;

	assign level_s = $signed({13'b0, pix_s1.bar_level});
	assign diff = level_s - thr_s1;

	always_comb begin
		unique case (cfg.pixel_format)
			bgys_pkg::FMT_YUV444: cvalid = 1'b1;
			bgys_pkg::FMT_YUV422: cvalid = !pix_s1.column_is_odd;
			default: cvalid = !pix_s1.column_is_odd && !pix_s1.row_index[0];
		endcase
	end

	// at or below the threshold the distance is zero, which shades black
	always_comb begin
		work_d.excess = (level_s > thr_s1) ? diff[bgys_pkg::EXCESS_W-1:0] : '0;
		work_d.rcp = pix_s1.level_reciprocal;
		work_d.luma = pix_s1.color_luma;
		work_d.cb = pix_s1.color_cb;
		work_d.cr = pix_s1.color_cr;
		work_d.chroma_valid = cvalid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pixel_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pixel_valid) begin
			pix_s1 <= pixel;
			thr_s1 <= thr;
		end
		if (ready_s2 && valid_s1) begin
			work_s2 <= work_d;
		end
	end

	assign work_valid = valid_s2;
	assign work = work_s2;

endmodule

/* design/bgys_queue.sv */
`timescale 1ns / 1ps

module bgys_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  bgys_pkg::work_t      push_data,
	input  logic                pop,
	output bgys_pkg::work_t      head,
	output bgys_pkg::q_status_t  status
);

	bgys_pkg::work_t                  mem [bgys_pkg::QUEUE_DEPTH];
	logic [bgys_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bgys_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bgys_pkg::QPTR_W:0]        count_q;
	logic                             push;

	assign status.full = (count_q == (bgys_pkg::QPTR_W + 1)'(bgys_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign push_ready = !status.full;
	assign push = push_valid && !status.full;
	assign head = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/bgys_back.sv */
`timescale 1ns / 1ps

module bgys_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bgys_pkg::q_status_t  q_status,
	input  bgys_pkg::work_t      head,
	output logic                pop,
	output logic                shade_valid,
	input  logic                shade_stall,
	output bgys_pkg::shade_t     shade
);

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	function automatic logic [7:0] blend(logic [32:0] mul, logic [7:0] color,
			logic [7:0] black);
		logic signed [8:0]  dc;
		logic signed [43:0] acc;
		dc = $signed({1'b0, color}) - $signed({1'b0, black});
		acc = $signed({1'b0, mul}) * dc;
		acc = acc + $signed({4'b0, black, 32'h8000_0000});
		return acc[39:32];
	endfunction

	logic            valid_s1;
	logic [49:0]     prod_s1;
	bgys_pkg::work_t work_s1;
	logic            valid_s2;
	bgys_pkg::shade_t shade_s2;

	logic            ready_s1;
	logic            ready_s2;
	logic [32:0]     mul;
	bgys_pkg::shade_t shade_d;

	assign ready_s2 = !valid_s2 || !shade_stall;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pop = !q_status.empty && ready_s1;

	assign mul = (prod_s1 > 50'(ONE_Q32)) ? ONE_Q32 : prod_s1[32:0];

	always_comb begin
		shade_d.luma_out = blend(mul, work_s1.luma, bgys_pkg::BLACK_LUMA);
		shade_d.cb_out = work_s1.chroma_valid ?
			blend(mul, work_s1.cb, bgys_pkg::BLACK_CHROMA) : bgys_pkg::BLACK_CHROMA;
		shade_d.cr_out = work_s1.chroma_valid ?
			blend(mul, work_s1.cr, bgys_pkg::BLACK_CHROMA) : bgys_pkg::BLACK_CHROMA;
		shade_d.chroma_valid = work_s1.chroma_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= !q_status.empty;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s1 <= 50'(head.excess) * 50'(head.rcp);
			work_s1 <= head;
		end
		if (ready_s2 && valid_s1) begin
			shade_s2 <= shade_d;
		end
	end

	assign shade_valid = valid_s2;
	assign shade = shade_s2;

endmodule

/* design/bar_graph_yuv_pixel_shader_top.sv */
`timescale 1ns / 1ps

// Shades one bar graph pixel per beat at a sustained rate of one pixel per clock while
// shade_stall is low; the back's output register drives shade.
// The front computes the row threshold (one 12x17 multiply) and the distance above it;
// a four-beat queue decouples it from the back, which forms the 26x24 blend factor in one
// stage, then saturates it and blends Y, and U and V where chroma is valid, in the next.
// Registers (cfg_index): 0 bar height, clamped to MAX_BAR_HEIGHT on write; 1 reciprocal of
// bar height, Q0.16; 2 chroma layout, 0 yuv444, 1 yuv422, 2 or 3 yuv420. Writes are
// always taken and must be made only while no pixel is in flight.
module bar_graph_yuv_pixel_shader_top #(
	parameter int unsigned MAX_BAR_HEIGHT = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  bgys_pkg::pixel_t  pixel,
	output logic             shade_valid,
	input  logic             shade_stall,
	output bgys_pkg::shade_t  shade
);

	bgys_pkg::cfg_t      cfg_q;
	logic                work_valid;
	logic                work_ready;
	bgys_pkg::work_t     work;
	logic                q_pop;
	bgys_pkg::work_t     q_head;
	bgys_pkg::q_status_t q_status;
	logic                q_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bar_height <= 11'd2;
			cfg_q.reciprocal_bar_height <= 16'd32768;
			cfg_q.pixel_format <= bgys_pkg::FMT_YUV444;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bgys_pkg::REG_BAR_HEIGHT: begin
					if ({21'b0, cfg_data[10:0]} > 32'(MAX_BAR_HEIGHT)) begin
						cfg_q.bar_height <= 11'(MAX_BAR_HEIGHT);
					end else begin
						cfg_q.bar_height <= cfg_data[10:0];
					end
				end
				bgys_pkg::REG_RECIPROCAL: cfg_q.reciprocal_bar_height <= cfg_data;
				bgys_pkg::REG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	bgys_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.work_valid  (work_valid),
		.work_ready  (work_ready),
		.work        (work)
	);

	bgys_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (work_valid),
		.push_ready (work_ready),
		.push_data  (work),
		.pop        (q_pop),
		.head       (q_head),
		.status     (q_status)
	);

	bgys_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_status    (q_status),
		.head        (q_head),
		.pop         (q_pop),
		.shade_valid (shade_valid),
		.shade_stall (shade_stall),
		.shade       (shade)
	);

	assign q_push = work_valid && work_ready;

	a_chroma_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		shade_valid && !shade.chroma_valid |->
			shade.cb_out == bgys_pkg::BLACK_CHROMA && shade.cr_out == bgys_pkg::BLACK_CHROMA)
		else $error("chroma not neutral on a pixel without chroma");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !q_push)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("queue popped while empty");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue status inconsistent");

endmodule

/* tb/bar_graph_shade_checker.sv */
`timescale 1ns / 1ps

module bar_graph_shade_checker
	import bgys_pkg::*;
#(
	parameter int unsigned MAX_BAR_HEIGHT = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        pixel_valid,
	input  logic        pixel_stall,
	input  pixel_t      pixel,
	input  logic        shade_valid,
	input  logic        shade_stall,
	input  shade_t      shade,
	output int          fail_count,
	output int          pixels_in,
	output int          shades_out,
	output int          dark_count,
	output int          lit_count
);

	localparam longint unsigned UNITY = 64'h1_0000_0000;
	localparam longint unsigned HALF = 64'h8000_0000;

	logic [10:0] height;
	logic [15:0] height_recip;
	logic [1:0]  layout;
	shade_t      expected_shades[$];
	shade_t      want;
	logic        dark;

	function automatic logic [7:0] fade(longint unsigned w, logic [7:0] c, logic [7:0] k);
		longint unsigned acc;
		acc = w * c + (UNITY - w) * k + HALF;
		return acc[39:32];
	endfunction

	function automatic shade_t shade_pixel(input pixel_t p, output logic is_dark);
		longint          thr;
		longint unsigned gain;
		shade_t          s;
		logic            chroma;
		thr = (longint'(height) - longint'(p.row_index)) * longint'(height_recip);
		is_dark = longint'(p.bar_level) <= thr;
		if (is_dark) begin
			s.luma_out = BLACK_LUMA;
			s.cb_out = BLACK_CHROMA;
			s.cr_out = BLACK_CHROMA;
		end else begin
			gain = longint'(longint'(p.bar_level) - thr) * longint'(p.level_reciprocal);
			if (gain > UNITY)
				gain = UNITY;
			s.luma_out = fade(gain, p.color_luma, BLACK_LUMA);
			s.cb_out = fade(gain, p.color_cb, BLACK_CHROMA);
			s.cr_out = fade(gain, p.color_cr, BLACK_CHROMA);
		end
		case (layout)
			FMT_YUV444: chroma = 1'b1;
			FMT_YUV422: chroma = !p.column_is_odd;
			default:    chroma = !p.column_is_odd && !p.row_index[0];
		endcase
		if (!chroma) begin
			s.cb_out = BLACK_CHROMA;
			s.cr_out = BLACK_CHROMA;
		end
		s.chroma_valid = chroma;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height <= 11'd2;
			height_recip <= 16'd32768;
			layout <= FMT_YUV444;
			fail_count <= 0;
			pixels_in <= 0;
			shades_out <= 0;
			dark_count <= 0;
			lit_count <= 0;
			expected_shades.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BAR_HEIGHT: height <= (cfg_data[10:0] > MAX_BAR_HEIGHT) ?
						11'(MAX_BAR_HEIGHT) : cfg_data[10:0];
					REG_RECIPROCAL: height_recip <= cfg_data;
					REG_PIXEL_FORMAT: layout <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (shade_valid && !shade_stall) begin
				shades_out <= shades_out + 1;
				if (expected_shades.size() == 0) begin
					if (fail_count < 10)
						$display("shade beat %0d arrived with nothing expected: Y %0d U %0d V %0d C %0b",
							shades_out, shade.luma_out, shade.cb_out, shade.cr_out,
							shade.chroma_valid);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_shades.pop_front();
					if (want.luma_out !== shade.luma_out || want.cb_out !== shade.cb_out ||
						want.cr_out !== shade.cr_out ||
						want.chroma_valid !== shade.chroma_valid) begin
						if (fail_count < 10)
							$display("shade beat %0d mismatch: expected Y %0d U %0d V %0d C %0b, got Y %0d U %0d V %0d C %0b",
								shades_out, want.luma_out, want.cb_out, want.cr_out,
								want.chroma_valid, shade.luma_out, shade.cb_out, shade.cr_out,
								shade.chroma_valid);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (pixel_valid && !pixel_stall) begin
				expected_shades.push_back(shade_pixel(pixel, dark));
				pixels_in <= pixels_in + 1;
				if (dark)
					dark_count <= dark_count + 1;
				else
					lit_count <= lit_count + 1;
			end
		end
	end

endmodule

/* tb/tb_bar_graph_yuv_pixel_shader_top.sv */
`timescale 1ns / 1ps

module tb_bar_graph_yuv_pixel_shader_top;
	import bgys_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam logic [1:0] FMT_YUV420 = 2'd2;
	localparam logic [1:0] FMT_SPARE_420 = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	pixel_t      pixel = '0;
	logic        shade_valid;
	logic        shade_stall = 1'b0;
	shade_t      shade;

	int fail_count, pixels_in, shades_out, dark_count, lit_count;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned settings_count = 1;
	int unsigned cur_bh = 2;

	stall_mode_e stall_mode = STALL_NONE;
	int unsigned mode_left = 0;
	int unsigned stall_tick = 0;

	bar_graph_yuv_pixel_shader_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.shade_valid (shade_valid),
		.shade_stall (shade_stall),
		.shade       (shade)
	);

	bar_graph_shade_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.shade_valid (shade_valid),
		.shade_stall (shade_stall),
		.shade       (shade),
		.fail_count  (fail_count),
		.pixels_in   (pixels_in),
		.shades_out  (shades_out),
		.dark_count  (dark_count),
		.lit_count   (lit_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (mode_left == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			mode_left <= $urandom_range(20, 300);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:     shade_stall <= 1'b0;
			STALL_RANDOM:   shade_stall <= ($urandom_range(0, 9) < 3);
			STALL_PERIODIC: shade_stall <= (stall_tick % 3) != 0;
			default:        shade_stall <= ($urandom_range(0, 15) != 0);
		endcase
	end

	function automatic pixel_t pix(logic [9:0] row, logic odd, logic [15:0] level,
		logic [23:0] rcp, logic [7:0] y, logic [7:0] u, logic [7:0] v);
		pixel_t p;
		p.row_index = row;
		p.column_is_odd = odd;
		p.bar_level = level;
		p.level_reciprocal = rcp;
		p.color_luma = y;
		p.color_cb = u;
		p.color_cr = v;
		return p;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t          p;
		longint unsigned q;
		int unsigned     pick;
		pick = $urandom_range(0, 9);
		p.row_index = (pick < 7) ? 10'($urandom_range(0, (cur_bh > 1023) ? 1023 : cur_bh)) :
			10'($urandom_range(0, 1023));
		p.column_is_odd = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			p.bar_level = 16'h0000;
		else if (pick == 1)
			p.bar_level = 16'hFFFF;
		else
			p.bar_level = 16'($urandom());
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			q = (p.bar_level == 0) ? 64'hFF_FFFF : 64'h1_0000_0000 / p.bar_level;
			p.level_reciprocal = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
		end else if (pick < 8) begin
			p.level_reciprocal = 24'($urandom());
		end else if (pick == 8) begin
			p.level_reciprocal = 24'h0;
		end else begin
			p.level_reciprocal = 24'hFF_FFFF;
		end
		p.color_luma = 8'($urandom());
		p.color_cb = 8'($urandom());
		p.color_cr = 8'($urandom());
		return p;
	endfunction

	task automatic push_pixel(input pixel_t p);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150) :
				$urandom_range(1, 12);
		end
		pixel <= p;
		pixel_valid <= 1'b1;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		burst_left--;
	endtask

	task automatic settle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pixels_in != shades_out) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic run_phase(input logic [15:0] h, input logic [15:0] recip,
		input logic [1:0] fmt, input int unsigned n);
		settle();
		write_reg(REG_BAR_HEIGHT, h);
		write_reg(REG_RECIPROCAL, recip);
		write_reg(REG_PIXEL_FORMAT, {14'd0, fmt});
		cfg_valid <= 1'b0;
		cur_bh = (h[10:0] > 1024) ? 1024 : h[10:0];
		settings_count++;
		repeat (n) push_pixel(random_pixel());
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: bar height 2, half-scale step per row, yuv444
		push_pixel(pix(10'd0, 1'b0, 16'hFFFF, 24'hFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		push_pixel(pix(10'd1, 1'b1, 16'h8000, 24'h01_0000, 8'h00, 8'h00, 8'h00));
		push_pixel(pix(10'd1, 1'b0, 16'h8001, 24'hFF_FFFF, 8'hFF, 8'h00, 8'hFF));
		push_pixel(pix(10'd2, 1'b1, 16'h0000, 24'hFF_FFFF, 8'hFF, 8'hFF, 8'hFF));
		push_pixel(pix(10'd2, 1'b0, 16'h0001, 24'hFF_FFFF, 8'hAA, 8'h55, 8'hAA));
		push_pixel(pix(10'd2, 1'b1, 16'h0200, 24'h80_0000, 8'h55, 8'hAA, 8'h55));
		push_pixel(pix(10'd2, 1'b0, 16'h0100, 24'h80_0000, 8'hFF, 8'h00, 8'hFF));
		push_pixel(pix(10'd3, 1'b1, 16'hFFFF, 24'hFF_FFFF, 8'hFF, 8'hFF, 8'h00));
		push_pixel(pix(10'd3, 1'b0, 16'h0000, 24'h00_0000, 8'hFF, 8'hFF, 8'hFF));
		push_pixel(pix(10'd1023, 1'b1, 16'hFFFF, 24'h00_0001, 8'h00, 8'h00, 8'h00));
		push_pixel(pix(10'h2AA, 1'b0, 16'hAAAA, 24'hAA_AAAA, 8'h12, 8'h34, 8'h56));
		push_pixel(pix(10'h155, 1'b1, 16'h5555, 24'h55_5555, 8'hED, 8'hCB, 8'hA9));
		push_pixel(pix(10'd2, 1'b0, 16'h8000, 24'h02_0000, 8'h10, 8'h80, 8'h80));
		push_pixel(pix(10'd1, 1'b1, 16'hFFFF, 24'h01_0001, 8'hC8, 8'h20, 8'hF0));
		repeat (30) push_pixel(random_pixel());

		run_phase(16'd1024, 16'd64, FMT_YUV444, 130);
		// above the maximum: clamps to the full bar area
		run_phase(16'd2047, 16'd64, FMT_YUV422, 120);
		run_phase(16'd2, 16'd32768, FMT_YUV420, 120);
		run_phase(16'd480, 16'd136, FMT_SPARE_420, 120);
		// upper data bits fall outside the height field
		run_phase(16'h0810, 16'd4096, FMT_YUV422, 120);
		run_phase(16'd256, 16'd0, FMT_YUV444, 110);
		run_phase(16'd64, 16'hFFFF, FMT_YUV420, 110);
		run_phase(16'd100, 16'd655, FMT_YUV422, 120);
		run_phase(16'd1024, 16'd32768, FMT_YUV444, 100);

		settle();
		repeat (20) @(posedge clk);

		$display("covered %0d pixels over %0d register settings:", pixels_in, settings_count);
		$display("%0d below threshold, %0d blended", dark_count, lit_count);
		if (pixels_in != shades_out)
			$display("%0d shades never arrived", pixels_in - shades_out);
		if (fail_count == 0 && pixels_in == shades_out)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
